>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CRPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that is also checked during reset.
`define CRPC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> sv/crpc_pkg.sv
`default_nettype none

package crpc_pkg;

   localparam int ReplyBufferBytes = 64;
   localparam int LenWidth = $clog2(ReplyBufferBytes);

   localparam logic [1:0] PhSearch = 2'd0;
   localparam logic [1:0] PhComp   = 2'd1;
   localparam logic [1:0] PhDone   = 2'd2;
   localparam logic [1:0] PhFail   = 2'd3;

   localparam logic [1:0] ModeUnknown = 2'd0;
   localparam logic [1:0] ModeDark    = 2'd1;
   localparam logic [1:0] ModeLight   = 2'd2;
   localparam logic [1:0] ModeMixed   = 2'd3;

   localparam logic [0:0] CsrDarkThreshold  = 1'd0;
   localparam logic [0:0] CsrLightThreshold = 1'd1;

   localparam logic [7:0] CharBel       = 8'h07;
   localparam logic [7:0] CharEsc       = 8'h1B;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharSlash     = 8'h2F;

   localparam logic [7:0] PrefixText [4] = '{8'h72, 8'h67, 8'h62, 8'h3A};

   localparam logic [7:0] DarkReset  = 8'd96;
   localparam logic [7:0] LightReset = 8'd160;

   localparam int SumWidth = 22;
   localparam logic [SumWidth-1:0] WeightRed   = 22'd2126;
   localparam logic [SumWidth-1:0] WeightGreen = 22'd7152;
   localparam logic [SumWidth-1:0] WeightBlue  = 22'd722;
   localparam logic [SumWidth-1:0] WeightScale = 22'd10000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       no_more;
   } in_item_type;

   typedef struct packed {
      logic       emit;
      logic       color_valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } reply_type;

endpackage

`default_nettype wire

>>> sv/color_reply_parse_classify_core.sv
`default_nettype none

// Parses a terminal's background color reply and classifies it as dark, light,
// mixed, or unknown when no color is parsed. One reply byte is taken per transfer
// on the req_ channel, one byte per clock cycle unless a reply end waits. Each
// reply gives exactly one rsp_ transfer, which becomes valid once the byte that
// ends the reply has passed the input register and parsing and the luminance
// compare have loaded the result register. A reply ends at BEL, at ESC backslash
// from byte index 3 on, after 63 stored bytes, or at a transfer with no_more set.
// A stalled result holds in the result register while the next byte is still
// taken; only a second reply end waits. Threshold writes on the csr_ channel are
// taken in any cycle and act at once, so write them between replies.
module color_reply_parse_classify_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] no_more
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [1:0] mode, [9:2] red, [17:10] green,
                                         // [25:18] blue, [31:26] zero
   output logic             rsp_tuser,   // [0] color_valid
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic                  in_vld_ff;
   crpc_pkg::in_item_type in_item_ff;
   logic [7:0]            dark_ff;
   logic [7:0]            light_ff;
   logic                  rsp_vld_ff;
   logic [1:0]            rsp_mode_ff;
   logic                  rsp_valid_color_ff;
   logic [7:0]            rsp_red_ff;
   logic [7:0]            rsp_green_ff;
   logic [7:0]            rsp_blue_ff;

   crpc_pkg::reply_type reply;
   logic [1:0]          mode;
   logic                out_free;
   logic                advance;

   crpc_parser u_parser (
      .clock (clock),
      .reset (reset),
      .item  (in_item_ff),
      .step  (advance),
      .reply (reply)
   );

   crpc_classify u_classify (
      .reply           (reply),
      .dark_threshold  (dark_ff),
      .light_threshold (light_ff),
      .mode            (mode)
   );

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && (!reply.emit || out_free);
   assign req_tready = !in_vld_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_item_ff.data_byte <= req_tdata;
         in_item_ff.no_more   <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff  <= crpc_pkg::DarkReset;
         light_ff <= crpc_pkg::LightReset;
      end else if (csr_valid && csr_index[1] == 1'b0) begin
         if (csr_index[0:0] == crpc_pkg::CsrDarkThreshold) begin
            dark_ff <= csr_data;
         end
         if (csr_index[0:0] == crpc_pkg::CsrLightThreshold) begin
            light_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && reply.emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance && reply.emit) begin
         rsp_mode_ff        <= mode;
         rsp_valid_color_ff <= reply.color_valid;
         rsp_red_ff         <= reply.red;
         rsp_green_ff       <= reply.green;
         rsp_blue_ff        <= reply.blue;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_blue_ff, rsp_green_ff, rsp_red_ff, rsp_mode_ff};
   assign rsp_tuser  = rsp_valid_color_ff;

endmodule

`default_nettype wire

>>> sv/crpc_parser.sv
`default_nettype none

module crpc_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crpc_pkg::in_item_type item,
   input  wire logic                 step,
   output crpc_pkg::reply_type       reply
);

   logic [1:0]                   phase_ff, fed_phase;
   logic [1:0]                   pmc_ff, fed_pmc;
   logic [1:0]                   comp_ff, fed_comp;
   logic [2:0]                   digits_ff, fed_digits;
   logic [15:0]                  acc_ff, fed_acc;
   logic [7:0]                   red_ff, fed_red;
   logic [7:0]                   green_ff, fed_green;
   logic [crpc_pkg::LenWidth-1:0] len_ff;
   logic                         esc_ff;

   logic [7:0] c;
   logic [4:0] hex;
   logic       stop_early;
   logic       full;
   logic [1:0] sel_phase;
   logic [7:0] sel_red;
   logic [7:0] sel_green;
   logic [7:0] sel_blue;

   // Returns the nibble in the low bits and sets the top bit for a non-hex byte.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b0, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b0, 4'(b - 8'h57)};
      end
      return r;
   endfunction

   assign c   = item.data_byte;
   assign hex = hex_nibble(c);

   always_comb begin
      fed_phase  = phase_ff;
      fed_pmc    = pmc_ff;
      fed_comp   = comp_ff;
      fed_digits = digits_ff;
      fed_acc    = acc_ff;
      fed_red    = red_ff;
      fed_green  = green_ff;
      unique case (phase_ff)
         crpc_pkg::PhSearch: begin
            if (c == crpc_pkg::PrefixText[pmc_ff]) begin
               if (pmc_ff == 2'd3) begin
                  fed_pmc    = 2'd0;
                  fed_phase  = crpc_pkg::PhComp;
                  fed_comp   = 2'd0;
                  fed_digits = 3'd0;
                  fed_acc    = 16'd0;
               end else begin
                  fed_pmc = pmc_ff + 2'd1;
               end
            end else begin
               fed_pmc = (c == crpc_pkg::PrefixText[0]) ? 2'd1 : 2'd0;
            end
         end
         crpc_pkg::PhComp: begin
            if (c == crpc_pkg::CharSlash) begin
               if (comp_ff == 2'd2) begin
                  fed_phase = crpc_pkg::PhDone;
               end else begin
                  if (comp_ff == 2'd0) begin
                     fed_red = acc_ff[15:8];
                  end else begin
                     fed_green = acc_ff[15:8];
                  end
                  fed_comp   = comp_ff + 2'd1;
                  fed_digits = 3'd0;
                  fed_acc    = 16'd0;
               end
            end else if (digits_ff[2] || hex[4]) begin
               fed_phase = crpc_pkg::PhFail;
            end else begin
               fed_acc    = {acc_ff[11:0], hex[3:0]};
               fed_digits = digits_ff + 3'd1;
               if (digits_ff == 3'd3 && comp_ff == 2'd2) begin
                  fed_phase = crpc_pkg::PhDone;
               end
            end
         end
         crpc_pkg::PhDone: begin
         end
         crpc_pkg::PhFail: begin
         end
      endcase
   end

   assign stop_early = item.no_more || (c == crpc_pkg::CharBel) ||
                       ((len_ff > crpc_pkg::LenWidth'(2)) && esc_ff &&
                        (c == crpc_pkg::CharBackslash));
   assign full = (len_ff >= crpc_pkg::LenWidth'(crpc_pkg::ReplyBufferBytes - 2));

   always_comb begin
      if (stop_early) begin
         sel_phase = phase_ff;
         sel_red   = red_ff;
         sel_green = green_ff;
         sel_blue  = acc_ff[15:8];
      end else begin
         sel_phase = fed_phase;
         sel_red   = fed_red;
         sel_green = fed_green;
         sel_blue  = fed_acc[15:8];
      end
      reply.emit        = stop_early || full;
      reply.color_valid = (sel_phase == crpc_pkg::PhDone);
      reply.red         = reply.color_valid ? sel_red : 8'd0;
      reply.green       = reply.color_valid ? sel_green : 8'd0;
      reply.blue        = reply.color_valid ? sel_blue : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && reply.emit)) begin
         phase_ff  <= crpc_pkg::PhSearch;
         pmc_ff    <= 2'd0;
         comp_ff   <= 2'd0;
         digits_ff <= 3'd0;
         acc_ff    <= 16'd0;
         red_ff    <= 8'd0;
         green_ff  <= 8'd0;
         len_ff    <= '0;
         esc_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= fed_phase;
         pmc_ff    <= fed_pmc;
         comp_ff   <= fed_comp;
         digits_ff <= fed_digits;
         acc_ff    <= fed_acc;
         red_ff    <= fed_red;
         green_ff  <= fed_green;
         len_ff    <= len_ff + crpc_pkg::LenWidth'(1);
         esc_ff    <= (c == crpc_pkg::CharEsc);
      end
   end

endmodule

`default_nettype wire

>>> sv/crpc_classify.sv
`default_nettype none

module crpc_classify (
   input  wire crpc_pkg::reply_type reply,
   input  wire logic [7:0]          dark_threshold,
   input  wire logic [7:0]          light_threshold,
   output logic [1:0]               mode
);

   logic [crpc_pkg::SumWidth-1:0] sum;
   logic [crpc_pkg::SumWidth-1:0] dark_limit;
   logic [crpc_pkg::SumWidth-1:0] light_limit;

   assign sum = crpc_pkg::SumWidth'(reply.red) * crpc_pkg::WeightRed +
                crpc_pkg::SumWidth'(reply.green) * crpc_pkg::WeightGreen +
                crpc_pkg::SumWidth'(reply.blue) * crpc_pkg::WeightBlue;
   assign dark_limit  = crpc_pkg::SumWidth'(dark_threshold) * crpc_pkg::WeightScale;
   assign light_limit = crpc_pkg::SumWidth'(light_threshold) * crpc_pkg::WeightScale;

   always_comb begin
      if (!reply.color_valid) begin
         mode = crpc_pkg::ModeUnknown;
      end else if (sum <= dark_limit) begin
         mode = crpc_pkg::ModeDark;
      end else if (sum >= light_limit) begin
         mode = crpc_pkg::ModeLight;
      end else begin
         mode = crpc_pkg::ModeMixed;
      end
   end

endmodule

`default_nettype wire

>>> sv/crpc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module crpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   logic mode_known;
   logic stop_taken;

   assign mode_known = (rsp_tdata[1:0] != crpc_pkg::ModeUnknown);
   assign stop_taken = req_tvalid && req_tready && req_tuser;

   `CRPC_ASSERT(a_rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   `CRPC_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, $past(reset) |-> !rsp_tvalid)

   `CRPC_ASSERT(a_mode_needs_color, clock, reset, rsp_tvalid && mode_known |-> rsp_tuser)

   `CRPC_ASSERT(a_stop_gives_result, clock, reset, stop_taken ##1 rsp_tready |=> rsp_tvalid)

endmodule

bind color_reply_parse_classify_core crpc_checker u_crpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> verif/color_reply_parse_classify_core_tb.sv
`timescale 1ns / 1ps

module color_reply_parse_classify_core_tb;

   localparam int PhaseCount = 8;
   localparam int ItemsPerPhase = 120;
   localparam int DirectedRows = 24;
   localparam int WatchdogLimit = 2000;
   localparam logic [1:0] CsrSpareLow  = 2'd2;
   localparam logic [1:0] CsrSpareHigh = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic       valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_result_type;

   typedef struct packed {
      crpc_pkg::in_item_type item;
      logic                  want_unknown;
   } directed_row_type;

   localparam color_result_type NoColor = '{crpc_pkg::ModeUnknown, 1'b0, 8'd0, 8'd0, 8'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [7:0]  csr_data = 8'd0;

   // Predictor state: thresholds and the parse of the reply in progress.
   logic [7:0]  dark_level = crpc_pkg::DarkReset;
   logic [7:0]  light_level = crpc_pkg::LightReset;
   logic [2:0]  seen_prefix = '0;
   logic [1:0]  phase = crpc_pkg::PhSearch;
   logic [1:0]  comp_idx = '0;
   logic [2:0]  nibble_count = '0;
   logic [15:0] hex_acc = '0;
   logic [7:0]  red_hold = '0;
   logic [7:0]  green_hold = '0;
   logic [6:0]  stored_len = '0;
   logic        last_was_esc = 1'b0;

   color_result_type      expected_colors [$];
   crpc_pkg::in_item_type outgoing [$];
   directed_row_type      directed [DirectedRows];
   int                    mismatches = 0;
   int                    items_sent = 0;
   int                    stall_cycles = 0;
   bit                    quiet_stretch = 1'b0;

   color_reply_parse_classify_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic bit take_break();
      return !quiet_stretch && ($urandom_range(0, 99) < 17);
   endfunction

   function automatic directed_row_type dir_row(input logic [7:0] b, input logic stop,
                                                input logic want_unknown);
      return '{'{b, stop}, want_unknown};
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic predict_reply_byte(input logic [7:0] c, input logic stop,
                                     output bit fired, output color_result_type res);
      logic [4:0] nib;
      logic [7:0] v;
      int sum;
      fired = 1'b0;
      res = NoColor;
      if (stop || c == crpc_pkg::CharBel ||
          (stored_len > 2 && last_was_esc && c == crpc_pkg::CharBackslash)) begin
         fired = 1'b1;
      end else begin
         if (phase == crpc_pkg::PhSearch) begin
            if (c == crpc_pkg::PrefixText[seen_prefix[1:0]]) begin
               seen_prefix++;
               if (seen_prefix >= 4) begin
                  seen_prefix = '0;
                  phase = crpc_pkg::PhComp;
                  comp_idx = '0;
                  nibble_count = '0;
                  hex_acc = '0;
               end
            end else begin
               seen_prefix = (c == crpc_pkg::PrefixText[0]) ? 3'd1 : 3'd0;
            end
         end else if (phase == crpc_pkg::PhComp) begin
            if (c == crpc_pkg::CharSlash) begin
               v = hex_acc[15:8];
               if (comp_idx == 2'd0) begin
                  red_hold = v;
               end else if (comp_idx == 2'd1) begin
                  green_hold = v;
               end
               if (comp_idx >= 2'd2) begin
                  phase = crpc_pkg::PhDone;
               end else begin
                  comp_idx++;
                  nibble_count = '0;
                  hex_acc = '0;
               end
            end else if (nibble_count >= 4) begin
               phase = crpc_pkg::PhFail;
            end else begin
               if (c >= "0" && c <= "9") nib = 5'(c - "0");
               else if (c >= "A" && c <= "F") nib = 5'(c - "A" + 10);
               else if (c >= "a" && c <= "f") nib = 5'(c - "a" + 10);
               else nib = 5'd16;
               if (nib > 15) begin
                  phase = crpc_pkg::PhFail;
               end else begin
                  hex_acc = {hex_acc[11:0], nib[3:0]};
                  nibble_count++;
                  if (nibble_count >= 4 && comp_idx >= 2'd2) phase = crpc_pkg::PhDone;
               end
            end
         end
         stored_len++;
         last_was_esc = (c == crpc_pkg::CharEsc);
         if (stored_len >= crpc_pkg::ReplyBufferBytes - 1) fired = 1'b1;
      end
      if (fired) begin
         if (phase == crpc_pkg::PhDone) begin
            res.valid = 1'b1;
            res.red = red_hold;
            res.green = green_hold;
            res.blue = hex_acc[15:8];
            sum = 2126 * res.red + 7152 * res.green + 722 * res.blue;
            if (sum <= int'(dark_level) * 10000) res.mode = crpc_pkg::ModeDark;
            else if (sum >= int'(light_level) * 10000) res.mode = crpc_pkg::ModeLight;
            else res.mode = crpc_pkg::ModeMixed;
         end
         seen_prefix = '0;
         phase = crpc_pkg::PhSearch;
         comp_idx = '0;
         nibble_count = '0;
         hex_acc = '0;
         red_hold = '0;
         green_hold = '0;
         stored_len = '0;
         last_was_esc = 1'b0;
      end
   endtask

   // Called right after a falling edge; returns right after a falling edge.
   task automatic send_item(input crpc_pkg::in_item_type it, input logic want_unknown);
      bit fired;
      color_result_type res;
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= it.data_byte;
      req_tuser <= it.no_more;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_reply_byte(it.data_byte, it.no_more, fired, res);
      if (want_unknown) expected_colors.push_back(NoColor);
      else if (fired) expected_colors.push_back(res);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_replies(input int extra);
      req_tvalid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_thresholds(input logic [7:0] dark, input logic [7:0] light,
                                  input bit poke_spare);
      logic [1:0] idx [4];
      logic [7:0] val [4];
      idx = '{2'(crpc_pkg::CsrDarkThreshold), 2'(crpc_pkg::CsrLightThreshold),
              CsrSpareLow, CsrSpareHigh};
      val = '{dark, light, 8'($urandom), 8'($urandom)};
      for (int k = 0; k < (poke_spare ? 4 : 2); k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (idx[k] == 2'(crpc_pkg::CsrDarkThreshold)) dark_level = val[k];
         else if (idx[k] == 2'(crpc_pkg::CsrLightThreshold)) light_level = val[k];
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic void push_byte(input logic [7:0] c);
      outgoing.push_back('{c, 1'b0});
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] picks [8];
      picks = '{crpc_pkg::CharEsc, crpc_pkg::CharBackslash, crpc_pkg::CharBel,
                crpc_pkg::CharSlash, "r", "g", "b", ":"};
      if ($urandom_range(0, 1)) return picks[$urandom_range(0, 7)];
      return 8'($urandom);
   endfunction

   task automatic build_reply();
      int shape;
      int ndig;
      logic [15:0] value;
      logic [3:0] nib;
      int pos;
      shape = $urandom_range(0, 99);
      outgoing.delete();
      if (shape < 85) begin
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(8'h20, 8'h7E)));
         push_byte("r");
         push_byte("g");
         push_byte("b");
         push_byte(":");
         for (int comp = 0; comp < 3; comp++) begin
            ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
            value = 16'($urandom);
            for (int k = 0; k < ndig; k++) begin
               nib = value[15 - 4 * k -: 4];
               if (nib < 10) push_byte(8'h30 + 8'(nib));
               else push_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
            end
            if (comp < 2 || ndig < 4) push_byte(crpc_pkg::CharSlash);
         end
         repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(8'h20, 8'h7E)));
         case ($urandom_range(0, 3))
            0: push_byte(crpc_pkg::CharBel);
            1: begin
               push_byte(crpc_pkg::CharEsc);
               push_byte(crpc_pkg::CharBackslash);
            end
            2: outgoing.push_back('{8'($urandom), 1'b1});
            default: begin
               while (outgoing.size() < crpc_pkg::ReplyBufferBytes - 1)
                  push_byte(8'($urandom_range(8'h20, 8'h5B)));
            end
         endcase
         if (shape >= 65) begin
            pos = $urandom_range(0, outgoing.size() - 1);
            outgoing[pos].data_byte = 8'($urandom);
            if ($urandom_range(0, 1)) begin
               repeat ($urandom_range(1, 4)) void'(outgoing.pop_back());
               outgoing.push_back('{8'($urandom), 1'b1});
            end
         end
      end else begin
         repeat ($urandom_range(0, 70)) push_byte(noise_byte());
         outgoing.push_back('{8'($urandom), 1'b1});
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= !take_break();
   end

   always @(posedge clock) begin
      color_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_colors.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), 0);
         end else begin
            want = expected_colors.pop_front();
            if (rsp_tdata[1:0] != want.mode)
               report_mismatch("mode", rsp_tdata[1:0], want.mode);
            if (rsp_tuser != want.valid)
               report_mismatch("color_valid", rsp_tuser, want.valid);
            if (rsp_tdata[9:2] != want.red)
               report_mismatch("red", rsp_tdata[9:2], want.red);
            if (rsp_tdata[17:10] != want.green)
               report_mismatch("green", rsp_tdata[17:10], want.green);
            if (rsp_tdata[25:18] != want.blue)
               report_mismatch("blue", rsp_tdata[25:18], want.blue);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("color_reply_parse_classify_core regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      directed = '{
         dir_row(8'h00, 1'b1, 1'b1),
         dir_row("r", 1'b0, 1'b0), dir_row("g", 1'b0, 1'b0),
         dir_row("b", 1'b0, 1'b0), dir_row(":", 1'b0, 1'b0),
         dir_row(crpc_pkg::CharBel, 1'b0, 1'b1),
         dir_row("r", 1'b0, 1'b0), dir_row("g", 1'b0, 1'b0),
         dir_row("b", 1'b0, 1'b0), dir_row(":", 1'b0, 1'b0),
         dir_row("g", 1'b0, 1'b0),
         dir_row(8'hFF, 1'b1, 1'b1),
         dir_row("r", 1'b0, 1'b0), dir_row("g", 1'b0, 1'b0),
         dir_row("b", 1'b0, 1'b0), dir_row(":", 1'b0, 1'b0),
         dir_row(crpc_pkg::CharSlash, 1'b0, 1'b0), dir_row(crpc_pkg::CharSlash, 1'b0, 1'b0),
         dir_row("F", 1'b0, 1'b0), dir_row("f", 1'b0, 1'b0),
         dir_row("F", 1'b0, 1'b0), dir_row("f", 1'b0, 1'b0),
         dir_row(crpc_pkg::CharEsc, 1'b0, 1'b0), dir_row(crpc_pkg::CharBackslash, 1'b0, 1'b0)
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_item(directed[i].item, directed[i].want_unknown);
      for (int ph = 0; ph < PhaseCount; ph++) begin
         if (ph > 0) begin
            drain_replies(4);
            case (ph)
               1: load_thresholds(8'd0, 8'd0, 1'b1);
               2: load_thresholds(8'd255, 8'd255, 1'b0);
               3: load_thresholds(8'd255, 8'd0, 1'b0);
               4: load_thresholds(8'd0, 8'd255, 1'b1);
               5: load_thresholds(8'd100, 8'd150, 1'b0);
               default: load_thresholds(8'($urandom_range(40, 120)),
                                        8'($urandom_range(120, 220)), 1'b1);
            endcase
         end
         quiet_stretch = (ph == 3);
         while (items_sent < DirectedRows + (ph + 1) * ItemsPerPhase) begin
            build_reply();
            foreach (outgoing[i]) send_item(outgoing[i], 1'b0);
         end
         send_item('{8'($urandom), 1'b1}, 1'b0);
      end
      quiet_stretch = 1'b0;
      drain_replies(8);
      if (mismatches == 0) begin
         $display("color_reply_parse_classify_core regression: pass");
      end else begin
         $display("color_reply_parse_classify_core regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/crpc_pkg.sv
sv/crpc_parser.sv
sv/crpc_classify.sv
sv/color_reply_parse_classify_core.sv
sv/crpc_checker.sv
verif/color_reply_parse_classify_core_tb.sv
